[sv/ptns_pkg.sv]
// Package: shared constants for the nearest point search block
package ptns_pkg;

	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] REG_GOAL_X = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GOAL_Y = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 2'd2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam int INDEX_BITS = 10;
	localparam int COUNT_BITS = 11;
	localparam int RADIUS_BITS = 16;

endpackage

[sv/ptns_if.sv]
// Interfaces: request and result channels
interface ptns_req_if #(
	parameter int COORD_BITS = 16
);
	logic valid;
	logic ready;
	logic func;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	modport source (output valid, func, point_x, point_y, input ready);
	modport sink (input valid, func, point_x, point_y, output ready);
endinterface

interface ptns_rsp_if;
	logic valid;
	logic ready;
	logic [ptns_pkg::INDEX_BITS-1:0] nearest_index;
	logic nearest_valid;
	logic goal_reached;
	logic [ptns_pkg::INDEX_BITS-1:0] goal_index;
	logic insert_dropped;
	logic [ptns_pkg::COUNT_BITS-1:0] point_count;
	modport source (output valid, nearest_index, nearest_valid, goal_reached, goal_index,
		insert_dropped, point_count, input ready);
	modport sink (input valid, nearest_index, nearest_valid, goal_reached, goal_index,
		insert_dropped, point_count, output ready);
endinterface

[sv/ptns_ram.sv]
// Generic single port RAM with registered read
module ptns_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

[sv/ptns_cell.sv]
// Distance cell: one stage of the squared distance chain
module ptns_cell #(
	parameter int COORD_BITS = 16,
	parameter int IDX_BITS = 10,
	parameter int STAGE = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vld_in,
	input  logic [IDX_BITS-1:0]          idx_in,
	input  logic [2*COORD_BITS+1:0]      acc_in,
	input  logic signed [COORD_BITS:0]   dx_in,
	input  logic signed [COORD_BITS:0]   dy_in,
	output logic                         vld_out,
	output logic [IDX_BITS-1:0]          idx_out,
	output logic [2*COORD_BITS+1:0]      acc_out,
	output logic signed [COORD_BITS:0]   dx_out,
	output logic signed [COORD_BITS:0]   dy_out
);
	// stage 0 squares dx, stage 1 adds the square of dy
	logic [COORD_BITS:0] mag;
	logic [2*COORD_BITS+1:0] sq;

	always_comb begin
		if (STAGE == 0) begin
			mag = dx_in[COORD_BITS] ? (COORD_BITS+1)'(0) - dx_in : dx_in;
		end else begin
			mag = dy_in[COORD_BITS] ? (COORD_BITS+1)'(0) - dy_in : dy_in;
		end
		sq = (2*COORD_BITS+2)'(mag) * (2*COORD_BITS+2)'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		idx_out <= idx_in;
		acc_out <= acc_in + sq;
		dx_out <= dx_in;
		dy_out <= dy_in;
	end
endmodule

[sv/point_table_nearest_search.sv]
// Top level: point table with goal test and nearest point scan
//  channel | dir | payload
//  req     | in  | func, point_x, point_y
//  rsp     | out | nearest_index, nearest_valid, goal_reached, goal_index,
//          |     | insert_dropped, point_count
//  cfg     | in  | cfg_we, cfg_index, cfg_data
// Insert: the RAM write and the two-cell distance chain lie between acceptance and result.
// Query: every stored entry is read in turn; one table entry enters the cell chain per cycle,
// set by the single RAM read port.
// Reset clears count and goal state; table contents stay undefined.
// A stalled result holds the block; the next request waits for the result to leave.
module point_table_nearest_search #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	ptns_req_if.sink req,
	ptns_rsp_if.source rsp,
	input  logic                                 cfg_we,
	input  logic [ptns_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [((COORD_BITS > ptns_pkg::RADIUS_BITS) ?
		COORD_BITS : ptns_pkg::RADIUS_BITS)-1:0] cfg_data
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int DW = 2 * COORD_BITS + 2;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_OUT = 3'd3;

	logic [2:0] state_q;
	logic [COORD_BITS-1:0] goal_x_q, goal_y_q;
	logic [ptns_pkg::RADIUS_BITS-1:0] radius_q;
	logic [CW-1:0] count_q;
	logic goal_seen_q;
	logic [AW-1:0] goal_entry_q;
	logic func_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [CW-1:0] rd_q;
	logic [2:0] drain_q;
	logic [AW-1:0] ram_addr;
	logic ram_we;
	logic [COORD_BITS-1:0] rx, ry;
	logic rv_s1;
	logic [AW-1:0] ridx_s1;
	logic goal_s1;
	logic signed [COORD_BITS:0] dx, dy;
	logic v_c0, v_c1;
	logic [AW-1:0] i_c0, i_c1;
	logic [DW-1:0] a_c0, a_c1;
	logic signed [COORD_BITS:0] dx_c0, dy_c0, dx_c1, dy_c1;
	logic [DW-1:0] best_q, lim_s1;
	logic [AW-1:0] best_idx_q;
	logic best_ok_q;
	logic dropped_q;
	logic acc_req;
	logic full;

	assign full = (count_q >= CW'(MAX_POINTS));
	assign req.ready = (state_q == ST_IDLE);
	assign acc_req = req.valid && req.ready;
	assign ram_we = acc_req && (req.func == ptns_pkg::FUNC_INSERT) && !full;
	assign ram_addr = acc_req ? count_q[AW-1:0] : rd_q[AW-1:0];

	ptns_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(req.point_x), .rdata(rx));
	ptns_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(req.point_y), .rdata(ry));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= '0;
			goal_y_q <= '0;
			radius_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ptns_pkg::REG_GOAL_X: goal_x_q <= COORD_BITS'(cfg_data);
				ptns_pkg::REG_GOAL_Y: goal_y_q <= COORD_BITS'(cfg_data);
				ptns_pkg::REG_RADIUS: radius_q <= ptns_pkg::RADIUS_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// goal test uses the incoming point directly; query uses RAM data
	always_comb begin
		if (goal_s1) begin
			dx = {px_q[COORD_BITS-1], px_q} - {goal_x_q[COORD_BITS-1], goal_x_q};
			dy = {py_q[COORD_BITS-1], py_q} - {goal_y_q[COORD_BITS-1], goal_y_q};
		end else begin
			dx = {px_q[COORD_BITS-1], px_q} - {rx[COORD_BITS-1], rx};
			dy = {py_q[COORD_BITS-1], py_q} - {ry[COORD_BITS-1], ry};
		end
	end

	ptns_cell #(.COORD_BITS(COORD_BITS), .IDX_BITS(AW), .STAGE(0)) u_c0 (
		.clk(clk), .arst_n(arst_n), .vld_in(rv_s1 || goal_s1), .idx_in(ridx_s1),
		.acc_in('0), .dx_in(dx), .dy_in(dy), .vld_out(v_c0), .idx_out(i_c0),
		.acc_out(a_c0), .dx_out(dx_c0), .dy_out(dy_c0));
	ptns_cell #(.COORD_BITS(COORD_BITS), .IDX_BITS(AW), .STAGE(1)) u_c1 (
		.clk(clk), .arst_n(arst_n), .vld_in(v_c0), .idx_in(i_c0),
		.acc_in(a_c0), .dx_in(dx_c0), .dy_in(dy_c0), .vld_out(v_c1), .idx_out(i_c1),
		.acc_out(a_c1), .dx_out(dx_c1), .dy_out(dy_c1));

	always_ff @(posedge clk) begin
		if (acc_req) begin
			px_q <= req.point_x;
			py_q <= req.point_y;
		end
		lim_s1 <= DW'(radius_q) * DW'(radius_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			goal_seen_q <= 1'b0;
			goal_entry_q <= '0;
			func_q <= 1'b0;
			rd_q <= '0;
			drain_q <= '0;
			rv_s1 <= 1'b0;
			ridx_s1 <= '0;
			goal_s1 <= 1'b0;
			best_q <= '0;
			best_idx_q <= '0;
			best_ok_q <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			rv_s1 <= 1'b0;
			goal_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_req) begin
						func_q <= req.func;
						best_ok_q <= 1'b0;
						best_idx_q <= '0;
						dropped_q <= 1'b0;
						rd_q <= '0;
						drain_q <= '0;
						if (req.func == ptns_pkg::FUNC_INSERT) begin
							dropped_q <= full;
							ridx_s1 <= count_q[AW-1:0];
							if (!full) begin
								count_q <= count_q + 1'b1;
								goal_s1 <= 1'b1;
							end
							state_q <= ST_DRAIN;
						end else begin
							state_q <= (count_q == '0) ? ST_DRAIN : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rv_s1 <= 1'b1;
					ridx_s1 <= rd_q[AW-1:0];
					if (rd_q + 1'b1 >= count_q) begin
						state_q <= ST_DRAIN;
					end
					rd_q <= rd_q + 1'b1;
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 3'd3) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (v_c1) begin
				if (func_q == ptns_pkg::FUNC_INSERT) begin
					if (a_c1 < lim_s1) begin
						goal_seen_q <= 1'b1;
						goal_entry_q <= i_c1;
					end
				end else if (!best_ok_q || a_c1 < best_q) begin
					best_ok_q <= 1'b1;
					best_q <= a_c1;
					best_idx_q <= i_c1;
				end
			end
		end
	end

	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.nearest_index = ptns_pkg::INDEX_BITS'(best_idx_q);
	assign rsp.nearest_valid = best_ok_q;
	assign rsp.goal_reached = goal_seen_q;
	assign rsp.goal_index = ptns_pkg::INDEX_BITS'(goal_entry_q);
	assign rsp.insert_dropped = dropped_q;
	assign rsp.point_count = ptns_pkg::COUNT_BITS'(count_q);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS)) else $error("count overflow");
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req.ready) else $error("ready while busy");
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.insert_dropped) |-> full) else $error("drop without full");
	a_ins_no_near: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && func_q == ptns_pkg::FUNC_INSERT) |-> !rsp.nearest_valid)
		else $error("insert with nearest");
`endif
endmodule
